[rtl/core/nca_pkg.sv]
// Shared types and constants for the nearest-centre assignment block.
package nca_pkg;

	// Default sizes handed to the top level.
	localparam int MAX_CENTERS_DEF = 64;
	localparam int MAX_DIMS_DEF    = 64;
	localparam int COORD_BITS_DEF  = 16;

	// Fixed field widths of the ports.
	localparam int SLOT_W    = 6;
	localparam int DIM_W     = 6;
	localparam int COORD_W   = 16;
	localparam int LABEL_W   = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ACC_W     = 39;
	localparam int DIST_W    = 38;

	// Saturation limits of the accumulators and of the reported distance.
	localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 1'd1;

	// Request kinds.
	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} nca_cmd_t;

	// One request as it travels along the chain of cells, with the running best.
	typedef struct packed {
		nca_cmd_t            kind;
		logic                first;
		logic                last;
		logic [SLOT_W-1:0]   slot;
		logic [DIM_W-1:0]    dim;
		logic [COORD_W-1:0]  coord;
		logic [ACC_W-1:0]    best;
		logic [LABEL_W-1:0]  label;
	} nca_tok_t;

endpackage

[rtl/core/nca_cell.sv]
// One cell of the chain: a centre's coordinates, its running distance and a best-so-far compare.
module nca_cell #(
	parameter int CELL_IDX   = 0,
	parameter int MAX_DIMS   = nca_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             active,
	input  logic             vld_i,
	input  nca_pkg::nca_tok_t tok_i,
	output logic             vld_o,
	output nca_pkg::nca_tok_t tok_o
);

	localparam int AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW    = COORD_BITS + 1;
	localparam int SQ_W  = 2 * DW;
	localparam int SUM_W = ((SQ_W > nca_pkg::ACC_W) ? SQ_W : nca_pkg::ACC_W) + 1;

	logic [COORD_BITS-1:0] mem [MAX_DIMS];

	logic [AW+nca_pkg::DIM_W-1:0]          dim_wide;
	logic [AW-1:0]                         addr;
	logic [COORD_BITS+nca_pkg::COORD_W-1:0] cin_wide;
	logic [COORD_BITS+nca_pkg::COORD_W-1:0] q_wide;
	logic [COORD_BITS-1:0]                 q_val;

	logic                  vld_s1;
	nca_pkg::nca_tok_t     tok_s1;
	logic [COORD_BITS-1:0] rd_s1;

	logic signed [DW-1:0]  diff;
	logic [DW-1:0]         mag;

	logic                  vld_s2;
	nca_pkg::nca_tok_t     tok_s2;
	logic [SQ_W-1:0]       sq_s2;

	logic [nca_pkg::ACC_W-1:0] acc_q;
	logic [nca_pkg::ACC_W-1:0] base;
	logic [SUM_W-1:0]          sum;
	logic [nca_pkg::ACC_W-1:0] new_acc;
	logic                      is_query_s2;

	// Address and coordinate taken from the incoming request.
	assign dim_wide = {{AW{1'b0}}, tok_i.dim};
	assign addr     = dim_wide[AW-1:0];
	assign cin_wide = {{COORD_BITS{1'b0}}, tok_i.coord};

	// Coordinate store of this centre, written by loads aimed at it, read by every request.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1  <= mem[addr];
			tok_s1 <= tok_i;
			if (vld_i && tok_i.kind == nca_pkg::CMD_LOAD && 32'(tok_i.slot) == CELL_IDX) begin
				mem[addr] <= cin_wide[COORD_BITS-1:0];
			end
		end
	end

	// Squared difference between query and centre coordinate.
	assign q_wide = {{COORD_BITS{1'b0}}, tok_s1.coord};
	assign q_val  = q_wide[COORD_BITS-1:0];
	assign diff   = $signed({q_val[COORD_BITS-1], q_val}) - $signed({rd_s1[COORD_BITS-1], rd_s1});
	assign mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_s1;
			sq_s2  <= mag * mag;
		end
	end

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	// Saturating accumulation; a first coordinate restarts the sum.
	// A centre outside the count in use keeps its running distance untouched.
	assign is_query_s2 = vld_s2 && tok_s2.kind == nca_pkg::CMD_QUERY;
	assign base        = tok_s2.first ? '0 : acc_q;
	assign sum         = SUM_W'(base) + SUM_W'(sq_s2);
	assign new_acc     = (sum > SUM_W'(nca_pkg::ACC_MAX)) ? nca_pkg::ACC_MAX
	                                                      : sum[nca_pkg::ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && is_query_s2 && active) begin
			acc_q <= new_acc;
		end
	end

	// A strictly smaller distance takes over, so the lower index keeps a tie.
	always_comb begin
		tok_o = tok_s2;
		if (active && is_query_s2 && new_acc < tok_s2.best) begin
			tok_o.best  = new_acc;
			tok_o.label = nca_pkg::LABEL_W'(CELL_IDX);
		end
	end

	assign vld_o = vld_s2;

endmodule

[rtl/core/nearest_center_assignment.sv]
// Top level of the nearest-centre assignment block: entry, chain of centre cells, result register.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   command, center_slot, dim_index, coord_value
//   out      out_valid / out_ready label, min_distance
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken every cycle while in_ready is high; a result passes through two
// register stages per centre cell, the first loaded by the edge that takes the last query
// coordinate, and then through the result register behind the last cell.
// Reset sets both counts to one and clears every running distance; the coordinate
// stores are not cleared and there is no clearing pass.
// While a result waits in the output register the whole chain holds and in_ready is low.
module nearest_center_assignment #(
	parameter int MAX_CENTERS = nca_pkg::MAX_CENTERS_DEF,
	parameter int MAX_DIMS    = nca_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS  = nca_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [nca_pkg::SLOT_W-1:0]      center_slot,
	input  logic [nca_pkg::DIM_W-1:0]       dim_index,
	input  logic signed [nca_pkg::COORD_W-1:0] coord_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nca_pkg::LABEL_W-1:0]     label,
	output logic [nca_pkg::DIST_W-1:0]      min_distance,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nca_pkg::CFG_W-1:0]       cfg_data
);

	logic [nca_pkg::CFG_W-1:0] num_centers_q;
	logic [nca_pkg::CFG_W-1:0] num_dims_q;
	logic [31:0]               nc_raw;
	logic [31:0]               nd_raw;
	logic [31:0]               nc;
	logic [31:0]               nd;

	logic              adv;
	logic              legal;
	logic              out_valid_q;
	logic [nca_pkg::LABEL_W-1:0] label_q;
	logic [nca_pkg::DIST_W-1:0]  dist_q;
	logic              emit;

	logic              vld_c [MAX_CENTERS+1];
	nca_pkg::nca_tok_t tok_c [MAX_CENTERS+1];

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_centers_q <= nca_pkg::CFG_W'(1);
			num_dims_q    <= nca_pkg::CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nca_pkg::REG_NUM_CENTERS: num_centers_q <= cfg_data;
				nca_pkg::REG_NUM_DIMS:    num_dims_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts clamped to the range the hardware holds.
	assign nc_raw = 32'(num_centers_q);
	assign nd_raw = 32'(num_dims_q);
	assign nc = (nc_raw == 0) ? 32'd1 : (nc_raw > 32'(MAX_CENTERS)) ? 32'(MAX_CENTERS) : nc_raw;
	assign nd = (nd_raw == 0) ? 32'd1 : (nd_raw > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : nd_raw;

	// The chain moves whenever the result register is free or being emptied.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Entry: loads outside the table and queries beyond the dimensions in use become bubbles.
	always_comb begin
		if (command == nca_pkg::CMD_LOAD) begin
			legal = 32'(center_slot) < 32'(MAX_CENTERS) && 32'(dim_index) < 32'(MAX_DIMS);
		end else begin
			legal = 32'(dim_index) < nd;
		end
	end

	assign vld_c[0]       = in_valid && adv && legal;
	assign tok_c[0].kind  = nca_pkg::nca_cmd_t'(command);
	assign tok_c[0].first = (dim_index == '0);
	assign tok_c[0].last  = (32'(dim_index) == nd - 32'd1);
	assign tok_c[0].slot  = center_slot;
	assign tok_c[0].dim   = dim_index;
	assign tok_c[0].coord = coord_value;
	assign tok_c[0].best  = nca_pkg::ACC_MAX;
	assign tok_c[0].label = '0;

	// One cell per centre.
	for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_cell
		nca_cell #(
			.CELL_IDX   (c),
			.MAX_DIMS   (MAX_DIMS),
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.active (32'(c) < nc),
			.vld_i  (vld_c[c]),
			.tok_i  (tok_c[c]),
			.vld_o  (vld_c[c+1]),
			.tok_o  (tok_c[c+1])
		);
	end

	// Result register at the end of the chain.
	assign emit = vld_c[MAX_CENTERS] && tok_c[MAX_CENTERS].kind == nca_pkg::CMD_QUERY &&
	              tok_c[MAX_CENTERS].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			label_q <= tok_c[MAX_CENTERS].label;
			dist_q  <= (tok_c[MAX_CENTERS].best > nca_pkg::ACC_W'(nca_pkg::DIST_MAX)) ?
			           nca_pkg::DIST_MAX : tok_c[MAX_CENTERS].best[nca_pkg::DIST_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign label        = label_q;
	assign min_distance = dist_q;

endmodule
